// ===== design/irft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irft_pkg: shared types and constants of the infrared frame transmitter
// register map, reset values and the timing bundle passed to the frame logic
// ----------------------------------------------------------------------------
package irft_pkg;

	// default data bits per frame
	localparam int FRAME_BITS_DEF = 32;

	// apb side
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// field widths
	localparam int START_MARK_W  = 11;
	localparam int START_SPACE_W = 11;
	localparam int BIT_TICKS_W   = 8;
	localparam int GAP_W         = 14;
	localparam int FRAME_TICK_W  = 16;
	localparam int PHASE_W       = 9;
	localparam int WORD_W        = 32;

	// frame boundaries: up to 4094 + 510 * 32 + 16383, fits 17 bits
	localparam int BOUND_W = 17;

	// reset values
	localparam int RST_START_MARK  = 818;
	localparam int RST_START_SPACE = 409;
	localparam int RST_BIT_MARK    = 50;
	localparam int RST_ZERO_SPACE  = 50;
	localparam int RST_ONE_SPACE   = 101;
	localparam int RST_GAP         = 2727;

	typedef enum logic [2:0] {
		REG_START_MARK  = 3'd0,
		REG_START_SPACE = 3'd1,
		REG_BIT_MARK    = 3'd2,
		REG_ZERO_SPACE  = 3'd3,
		REG_ONE_SPACE   = 3'd4,
		REG_GAP         = 3'd5
	} irft_reg_t;

	// timing seen by the frame logic
	typedef struct packed {
		logic [START_MARK_W-1:0] bound_a;     // end of start mark
		logic [BOUND_W-1:0]      bound_b;     // end of start space
		logic [BOUND_W-1:0]      bound_c;     // end of data window
		logic [BOUND_W-1:0]      bound_d;     // end of trailer and gap
		logic [BIT_TICKS_W-1:0]  bit_mark;
		logic [BIT_TICKS_W-1:0]  zero_space;
		logic [BIT_TICKS_W-1:0]  one_space;
	} irft_timing_t;

endpackage

// ===== design/ir_frame_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_frame_transmitter: pulse-distance infrared frame sender
// nec-style frames of FRAME_BITS bits, lsb first, stepped by half-carrier ticks,
// with key and rgb pending slots for requests that arrive while busy
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ---------------------------------
//  input    in         in_valid / in_ready     op, is_color, payload
//  result   out        out_valid / out_ready   ir_level, busy_res, frame_done
//  config   in         apb psel/penable/pready paddr, pwdata, prdata
//
//  one item per clock while out_ready holds; an item passes the input register,
//  then the result register
//  the whole tick or request update is one pass of logic on the frame state
//  the result register holds under a stall; the input register still takes one
//  more item, after which in_ready drops
//  arst_n clears the frame state and loads the register reset values; no
//  clearing pass is needed
//
module ir_frame_transmitter import irft_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic                  is_color,
	input  logic [WORD_W-1:0]     payload,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ir_level,
	output logic                  busy_res,
	output logic                  frame_done,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// bit index runs from 0 up to FRAME_BITS inclusive
	localparam int BIW = $clog2(FRAME_BITS + 1);

	irft_timing_t timing;

	// input register
	logic              valid_s1;
	logic              op_s1;
	logic              is_color_s1;
	logic [WORD_W-1:0] payload_s1;

	// result register
	logic valid_s2;
	logic level_s2;
	logic busy_s2;
	logic done_s2;

	// frame state
	logic [FRAME_TICK_W-1:0] frame_tick_q;
	logic [BIW-1:0]          bit_index_q;
	logic [PHASE_W-1:0]      phase_tick_q;
	logic                    need_load_q;
	logic [BIT_TICKS_W-1:0]  cur_space_q;
	logic                    pin_q;
	logic                    sending_q;
	logic [WORD_W-1:0]       shift_word_q;
	logic                    key_pend_q;
	logic [WORD_W-1:0]       key_word_q;
	logic                    color_pend_q;
	logic [WORD_W-1:0]       color_word_q;

	// next frame state
	logic [FRAME_TICK_W-1:0] frame_tick_d;
	logic [BIW-1:0]          bit_index_d;
	logic [PHASE_W-1:0]      phase_tick_d;
	logic                    need_load_d;
	logic [BIT_TICKS_W-1:0]  cur_space_d;
	logic                    pin_d;
	logic                    sending_d;
	logic [WORD_W-1:0]       shift_word_d;
	logic                    key_pend_d;
	logic [WORD_W-1:0]       key_word_d;
	logic                    color_pend_d;
	logic [WORD_W-1:0]       color_word_d;
	logic                    done_d;

	// step helpers
	logic [FRAME_TICK_W-1:0] ft_inc;
	logic [BOUND_W-1:0]      ft_ext;
	logic [PHASE_W-1:0]      ph_inc;
	logic [PHASE_W-1:0]      bit_len;
	logic [BIT_TICKS_W-1:0]  space_eff;
	logic [WORD_W-1:0]       sel_word;

	logic accept;
	logic advance;

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	irft_regs #(
		.FRAME_BITS (FRAME_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.timing  (timing)
	);

	assign pready = 1'b1;

	// ------------------------------------------------------------------------
	// handshake: input stage moves on whenever the result register is free
	// ------------------------------------------------------------------------
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			is_color_s1 <= is_color;
			payload_s1  <= payload;
		end
		if (advance) begin
			level_s2 <= pin_d;
			busy_s2  <= sending_d;
			done_s2  <= done_d;
		end
	end

	assign out_valid  = valid_s2;
	assign ir_level   = level_s2;
	assign busy_res   = busy_s2;
	assign frame_done = done_s2;

	// ------------------------------------------------------------------------
	// frame step: one request or one tick against the current frame state
	// ------------------------------------------------------------------------
	assign ft_inc   = frame_tick_q + FRAME_TICK_W'(1);
	assign ft_ext   = BOUND_W'(ft_inc);
	assign ph_inc   = phase_tick_q + PHASE_W'(1);
	assign sel_word = shift_word_q >> bit_index_q;
	// space length is latched on the first tick of each bit
	assign space_eff = need_load_q ? (sel_word[0] ? timing.one_space : timing.zero_space)
	                               : cur_space_q;
	assign bit_len   = {1'b0, timing.bit_mark} + {1'b0, space_eff};

	always_comb begin
		frame_tick_d = frame_tick_q;
		bit_index_d  = bit_index_q;
		phase_tick_d = phase_tick_q;
		need_load_d  = need_load_q;
		cur_space_d  = cur_space_q;
		pin_d        = pin_q;
		sending_d    = sending_q;
		shift_word_d = shift_word_q;
		key_pend_d   = key_pend_q;
		key_word_d   = key_word_q;
		color_pend_d = color_pend_q;
		color_word_d = color_word_q;
		done_d       = 1'b0;

		if (op_s1) begin
			// send request: start at once when idle, else park in a slot
			if (!sending_q) begin
				sending_d    = 1'b1;
				shift_word_d = payload_s1;
				frame_tick_d = '0;
				bit_index_d  = '0;
				phase_tick_d = '0;
				need_load_d  = 1'b1;
			end else if (is_color_s1) begin
				color_word_d = payload_s1;
				color_pend_d = 1'b1;
			end else begin
				key_word_d = payload_s1;
				key_pend_d = 1'b1;
			end
		end else if (sending_q) begin
			frame_tick_d = ft_inc;
			priority if (ft_ext < BOUND_W'(timing.bound_a)) begin
				// start mark: carrier
				pin_d = ~pin_q;
			end else if (ft_ext < timing.bound_b) begin
				// start space
				pin_d = 1'b0;
			end else if (ft_ext < timing.bound_c) begin
				if (bit_index_q >= BIW'(FRAME_BITS)) begin
					// all bits out early: skip to the trailer, pin untouched
					frame_tick_d = timing.bound_c[FRAME_TICK_W-1:0];
				end else begin
					need_load_d = 1'b0;
					cur_space_d = space_eff;
					pin_d       = (phase_tick_q < PHASE_W'(timing.bit_mark)) ? ~pin_q : 1'b0;
					if (ph_inc >= bit_len) begin
						phase_tick_d = '0;
						bit_index_d  = bit_index_q + BIW'(1);
						need_load_d  = 1'b1;
					end else begin
						phase_tick_d = ph_inc;
					end
				end
			end else if (ft_ext < timing.bound_d) begin
				// trailer mark, then low for the rest of the gap
				if (phase_tick_q < PHASE_W'(timing.bit_mark)) begin
					phase_tick_d = ph_inc;
					pin_d        = ~pin_q;
				end else begin
					pin_d = 1'b0;
				end
			end else begin
				// frame and gap over: key slot first, then rgb slot, else idle
				done_d       = 1'b1;
				frame_tick_d = '0;
				bit_index_d  = '0;
				phase_tick_d = '0;
				need_load_d  = 1'b1;
				if (key_pend_q) begin
					key_pend_d   = 1'b0;
					shift_word_d = key_word_q;
				end else if (color_pend_q) begin
					color_pend_d = 1'b0;
					shift_word_d = color_word_q;
				end else begin
					sending_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_tick_q <= '0;
			bit_index_q  <= '0;
			phase_tick_q <= '0;
			need_load_q  <= 1'b1;
			cur_space_q  <= '0;
			pin_q        <= 1'b0;
			sending_q    <= 1'b0;
			shift_word_q <= '0;
			key_pend_q   <= 1'b0;
			key_word_q   <= '0;
			color_pend_q <= 1'b0;
			color_word_q <= '0;
		end else if (advance) begin
			frame_tick_q <= frame_tick_d;
			bit_index_q  <= bit_index_d;
			phase_tick_q <= phase_tick_d;
			need_load_q  <= need_load_d;
			cur_space_q  <= cur_space_d;
			pin_q        <= pin_d;
			sending_q    <= sending_d;
			shift_word_q <= shift_word_d;
			key_pend_q   <= key_pend_d;
			key_word_q   <= key_word_d;
			color_pend_q <= color_pend_d;
			color_word_q <= color_word_d;
		end
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	// bit counter never runs past the frame length
	a_bit_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= BIW'(FRAME_BITS))
		else $error("bit index beyond frame length");

	// a parked word only exists while a frame is running
	a_pending_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(key_pend_q || color_pend_q) |-> sending_q)
		else $error("pending slot while idle");

	// a latched space belongs to a bit that is still to be finished
	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!need_load_q |-> (bit_index_q < BIW'(FRAME_BITS)))
		else $error("space latched with no bit left");

	// a new result always comes from an input item in flight
	a_done_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result without an item");

endmodule

// ===== design/irft_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irft_regs: configuration registers of the infrared frame transmitter
// apb write and read, plus frame boundaries derived from them
// ----------------------------------------------------------------------------
module irft_regs import irft_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output irft_timing_t          timing
);

	logic [START_MARK_W-1:0]  start_mark_q;
	logic [START_SPACE_W-1:0] start_space_q;
	logic [BIT_TICKS_W-1:0]   bit_mark_q;
	logic [BIT_TICKS_W-1:0]   zero_space_q;
	logic [BIT_TICKS_W-1:0]   one_space_q;
	logic [GAP_W-1:0]         gap_q;

	irft_reg_t          reg_idx;
	logic               wr_en;
	logic [PHASE_W-1:0] per_bit;
	logic [BOUND_W-1:0] sum_b;
	logic [BOUND_W-1:0] sum_c;
	logic [BOUND_W-1:0] sum_d;

	assign reg_idx = irft_reg_t'(paddr[4:2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark_q  <= START_MARK_W'(RST_START_MARK);
			start_space_q <= START_SPACE_W'(RST_START_SPACE);
			bit_mark_q    <= BIT_TICKS_W'(RST_BIT_MARK);
			zero_space_q  <= BIT_TICKS_W'(RST_ZERO_SPACE);
			one_space_q   <= BIT_TICKS_W'(RST_ONE_SPACE);
			gap_q         <= GAP_W'(RST_GAP);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_MARK:  start_mark_q  <= pwdata[START_MARK_W-1:0];
				REG_START_SPACE: start_space_q <= pwdata[START_SPACE_W-1:0];
				REG_BIT_MARK:    bit_mark_q    <= pwdata[BIT_TICKS_W-1:0];
				REG_ZERO_SPACE:  zero_space_q  <= pwdata[BIT_TICKS_W-1:0];
				REG_ONE_SPACE:   one_space_q   <= pwdata[BIT_TICKS_W-1:0];
				REG_GAP:         gap_q         <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_MARK:  prdata = APB_DATA_W'(start_mark_q);
			REG_START_SPACE: prdata = APB_DATA_W'(start_space_q);
			REG_BIT_MARK:    prdata = APB_DATA_W'(bit_mark_q);
			REG_ZERO_SPACE:  prdata = APB_DATA_W'(zero_space_q);
			REG_ONE_SPACE:   prdata = APB_DATA_W'(one_space_q);
			REG_GAP:         prdata = APB_DATA_W'(gap_q);
			default:         prdata = '0;
		endcase
	end

	// boundaries follow the registers in the same cycle as a write lands
	assign per_bit = {1'b0, bit_mark_q} + {1'b0, one_space_q};
	assign sum_b   = BOUND_W'(start_mark_q) + BOUND_W'(start_space_q);
	assign sum_c   = sum_b + BOUND_W'(per_bit * FRAME_BITS);
	assign sum_d   = sum_c + BOUND_W'(gap_q);

	assign timing.bound_a    = start_mark_q;
	assign timing.bound_b    = sum_b;
	assign timing.bound_c    = sum_c;
	assign timing.bound_d    = sum_d;
	assign timing.bit_mark   = bit_mark_q;
	assign timing.zero_space = zero_space_q;
	assign timing.one_space  = one_space_q;

endmodule
